// ===== rtl/core/pyrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed YUV to RGB converter package
// Shared types, sizes, conversion tables and the channel clamp.
// ----------------------------------------------------------------------------
package pyrc_pkg;

   typedef enum logic [1:0] {
      PACK_UYV    = 2'd0,
      PACK_UYVY   = 2'd1,
      PACK_UYYVYY = 2'd2
   } packing_type;

   localparam packing_type PACK_RESET = PACK_UYVY;

   localparam int GROUP_BYTES = 6;
   localparam int GROUP_PIXELS = 4;
   localparam int GROUP_FIFO_DEPTH = 2;
   localparam int PIXEL_FIFO_DEPTH = 4;

   localparam logic [31:0] MANT_R  = 32'd11762506;
   localparam logic [31:0] MANT_B  = 32'd14856225;
   localparam logic [31:0] MANT_G0 = 32'd11985643;
   localparam logic [31:0] MANT_G1 = 32'd11599767;
   localparam int DROP_R  = 23;
   localparam int DROP_B  = 23;
   localparam int DROP_G0 = 14;
   localparam int DROP_G1 = 15;
   localparam int GREEN_SHIFT = 10;
   localparam int ROM_SIZE = 256;
   localparam int MID_CODE = 128;

   typedef logic signed [17:0] rom_table_type [ROM_SIZE];

   typedef struct packed {
      logic [7:0]                    u;
      logic [7:0]                    v;
      logic [GROUP_PIXELS-1:0][7:0]  y;
      logic [1:0]                    last_index;
   } group_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       group_end;
   } pixel_type;

   function automatic logic [31:0] rom_mag(input logic [31:0] mant, input logic [31:0] n,
                                           input int drop);
      logic [63:0] p;
      logic [63:0] rem;
      logic [63:0] half;
      int          len;
      int          sh;
      p = 64'(mant) * 64'(n);
      len = 0;
      for (int i = 0; i < 64; i++) begin
         if (p[i]) begin
            len = i + 1;
         end
      end
      if (len > 24) begin
         sh = len - 24;
         rem = p & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         p = p >> sh;
         if (rem > half || (rem == half && p[0])) begin
            p = p + 64'd1;
         end
         p = p << sh;
      end
      return 32'(p >> drop);
   endfunction

   function automatic rom_table_type build_rom(input logic [31:0] mant, input int drop);
      rom_table_type tab;
      int            d;
      logic [31:0]   m;
      for (int idx = 0; idx < ROM_SIZE; idx++) begin
         d = idx - MID_CODE;
         m = rom_mag(mant, 32'(d < 0 ? -d : d), drop);
         tab[idx] = (d < 0) ? -18'(m) : 18'(m);
      end
      return tab;
   endfunction

   localparam rom_table_type ROM_R  = build_rom(MANT_R, DROP_R);
   localparam rom_table_type ROM_B  = build_rom(MANT_B, DROP_B);
   localparam rom_table_type ROM_G0 = build_rom(MANT_G0, DROP_G0);
   localparam rom_table_type ROM_G1 = build_rom(MANT_G1, DROP_G1);

   function automatic logic [7:0] clamp8(input logic signed [10:0] x);
      if (x < 0) begin
         return 8'd0;
      end else if (x > 11'sd255) begin
         return 8'd255;
      end
      return x[7:0];
   endfunction

endpackage

// ===== rtl/core/pyrc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed YUV to RGB converter queue
// Small first-in first-out queue of words with fill level.
// ----------------------------------------------------------------------------
module pyrc_fifo #(
   parameter int  DEPTH = 2,
   parameter type item_type = logic
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  item_type                   push_item,
   output logic                       full,
   input  logic                       pop,
   output item_type                   head,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   item_type          store_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff;
   logic [PW-1:0]     rd_ptr_in;
   logic [LW-1:0]     level_ff;
   logic [LW-1:0]     level_in;
   logic              do_push;
   logic              do_pop;

   assign full  = (level_ff == LW'(DEPTH));
   assign empty = (level_ff == '0);
   assign level = level_ff;
   assign head  = store_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LW'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/pyrc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed YUV to RGB converter front end
// Collects stream bytes into groups per packing mode and issues group words.
// ----------------------------------------------------------------------------
module pyrc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_write_data,
   input  logic                 byte_valid,
   input  logic [7:0]           byte_in,
   output logic                 grp_push,
   output pyrc_pkg::group_type  grp_item
);

   pyrc_pkg::packing_type mode_ff;
   logic [2:0]            pos_ff;
   logic [2:0]            pos_in;
   logic [7:0]            bytes_ff  [pyrc_pkg::GROUP_BYTES];
   logic [7:0]            bytes_now [pyrc_pkg::GROUP_BYTES];
   logic [2:0]            group_len;
   logic [2:0]            pos_eff;
   logic                  last_byte;

   always_comb begin
      unique case (mode_ff)
         pyrc_pkg::PACK_UYV:    group_len = 3'd3;
         pyrc_pkg::PACK_UYVY:   group_len = 3'd4;
         pyrc_pkg::PACK_UYYVYY: group_len = 3'd6;
         default:               group_len = 3'd0;
      endcase
   end

   assign pos_eff   = (pos_ff >= group_len) ? 3'd0 : pos_ff;
   assign last_byte = (pos_eff + 3'd1 == group_len);
   assign grp_push  = byte_valid && (group_len != 3'd0) && last_byte;

   always_comb begin
      for (int i = 0; i < pyrc_pkg::GROUP_BYTES; i++) begin
         bytes_now[i] = (pos_eff == 3'(i)) ? byte_in : bytes_ff[i];
      end
   end

   always_comb begin
      grp_item.u = bytes_now[0];
      grp_item.v = bytes_now[2];
      grp_item.y = {4{bytes_now[1]}};
      grp_item.last_index = 2'd0;
      unique case (mode_ff)
         pyrc_pkg::PACK_UYV: begin
            grp_item.last_index = 2'd0;
         end
         pyrc_pkg::PACK_UYVY: begin
            grp_item.y[1] = bytes_now[3];
            grp_item.last_index = 2'd1;
         end
         pyrc_pkg::PACK_UYYVYY: begin
            grp_item.v = bytes_now[3];
            grp_item.y = {bytes_now[5], bytes_now[4], bytes_now[2], bytes_now[1]};
            grp_item.last_index = 2'd3;
         end
         default: begin
            grp_item.last_index = 2'd0;
         end
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      if (byte_valid) begin
         if (group_len == 3'd0 || last_byte) begin
            pos_in = 3'd0;
         end else begin
            pos_in = pos_eff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pyrc_pkg::PACK_RESET;
         pos_ff  <= '0;
      end else if (csr_write_enable) begin
         mode_ff <= pyrc_pkg::packing_type'(csr_write_data);
         pos_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_valid && group_len != 3'd0) begin
         bytes_ff[pos_eff] <= byte_in;
      end
   end

endmodule

// ===== rtl/core/pyrc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed YUV to RGB converter back end
// Walks each group one pixel a cycle, while the pixel queue has room, through table lookup, sum and clamp.
// ----------------------------------------------------------------------------
module pyrc_back #(
   parameter int PIXEL_DEPTH = pyrc_pkg::PIXEL_FIFO_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 grp_empty,
   input  pyrc_pkg::group_type  grp_head,
   output logic                 grp_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output pyrc_pkg::pixel_type  rsp_pixel
);

   localparam int LW = $clog2(PIXEL_DEPTH + 1);

   logic [1:0]                pix_ff;
   logic [1:0]                pix_in;
   logic                      room;
   logic                      issue;
   logic                      issue_last;
   logic [7:0]                issue_y;
   logic                      stage_valid_ff;
   logic [7:0]                y_ff;
   logic signed [8:0]         r_ff;
   logic signed [8:0]         b_ff;
   logic signed [17:0]        g0_ff;
   logic signed [16:0]        g1_ff;
   logic                      last_ff;
   logic signed [18:0]        g_sum;
   logic signed [8:0]         g_shift;
   logic signed [10:0]        red_sum;
   logic signed [10:0]        green_sum;
   logic signed [10:0]        blue_sum;
   pyrc_pkg::pixel_type       out_pixel;
   logic                      out_full;
   logic [LW-1:0]             out_level;

   assign room = ((LW + 1)'(out_level) + (LW + 1)'(stage_valid_ff)) < (LW + 1)'(PIXEL_DEPTH);
   assign issue      = !grp_empty && room;
   assign issue_last = (pix_ff == grp_head.last_index);
   assign issue_y    = grp_head.y[pix_ff];
   assign grp_pop    = issue && issue_last;

   always_comb begin
      pix_in = pix_ff;
      if (issue) begin
         pix_in = issue_last ? 2'd0 : pix_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         pix_ff         <= pix_in;
         stage_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         y_ff    <= issue_y;
         r_ff    <= 9'(pyrc_pkg::ROM_R[grp_head.v]);
         b_ff    <= 9'(pyrc_pkg::ROM_B[grp_head.u]);
         g0_ff   <= pyrc_pkg::ROM_G0[grp_head.v];
         g1_ff   <= 17'(pyrc_pkg::ROM_G1[grp_head.u]);
         last_ff <= issue_last;
      end
   end

   assign g_sum     = 19'(g0_ff) + 19'(g1_ff);
   assign g_shift   = 9'(g_sum >>> pyrc_pkg::GREEN_SHIFT);
   assign red_sum   = $signed({3'b000, y_ff}) + 11'(r_ff);
   assign green_sum = $signed({3'b000, y_ff}) - 11'(g_shift);
   assign blue_sum  = $signed({3'b000, y_ff}) + 11'(b_ff);

   assign out_pixel.red       = pyrc_pkg::clamp8(red_sum);
   assign out_pixel.green     = pyrc_pkg::clamp8(green_sum);
   assign out_pixel.blue      = pyrc_pkg::clamp8(blue_sum);
   assign out_pixel.group_end = last_ff;

   pyrc_fifo #(
      .DEPTH     (PIXEL_DEPTH),
      .item_type (pyrc_pkg::pixel_type)
   ) u_pixel_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (stage_valid_ff),
      .push_item (out_pixel),
      .full      (out_full),
      .pop       (rsp_pop),
      .head      (rsp_pixel),
      .empty     (rsp_empty),
      .level     (out_level)
   );

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff |-> !out_full)
      else $error("pixel word arrived at a full queue");
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      grp_pop |-> (pix_ff == grp_head.last_index))
      else $error("group dropped before its last pixel");
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      !grp_empty |-> (pix_ff <= grp_head.last_index))
      else $error("pixel index past end of group");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      grp_pop |=> (pix_ff == 2'd0))
      else $error("pixel index not restarted after group");
`endif

endmodule

// ===== rtl/core/packed_yuv_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// Path: a completed group goes into the group queue; each pixel then loads the lookup
// stage registers and then the pixel queue that drives rsp_, one a cycle while it has room.
// Throughput: one byte accepted per cycle unless full, one pixel delivered per cycle
// while the pixel queue has room, set by the back end's single lookup-and-clamp lane.
// Reset: synchronous, active high; packing mode returns to 4:2:2, group position
// and both queues clear.
// ----------------------------------------------------------------------------
// Packed YUV to RGB converter
// Byte stream in, clamped RGB pixels out, via a group queue between two halves.
// ----------------------------------------------------------------------------
module packed_yuv_to_rgb_converter #(
   parameter int GROUP_DEPTH = pyrc_pkg::GROUP_FIFO_DEPTH,
   parameter int PIXEL_DEPTH = pyrc_pkg::PIXEL_FIFO_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_byte_in,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_group_end
);

   logic                                grp_push;
   pyrc_pkg::group_type                 grp_item;
   logic                                grp_full;
   logic                                grp_pop;
   pyrc_pkg::group_type                 grp_head;
   logic                                grp_empty;
   logic [$clog2(GROUP_DEPTH+1)-1:0]    grp_level;
   pyrc_pkg::pixel_type                 rsp_pixel;
   logic                                byte_valid;

   assign full       = grp_full;
   assign byte_valid = push && !grp_full;

   pyrc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .byte_valid       (byte_valid),
      .byte_in          (req_byte_in),
      .grp_push         (grp_push),
      .grp_item         (grp_item)
   );

   pyrc_fifo #(
      .DEPTH     (GROUP_DEPTH),
      .item_type (pyrc_pkg::group_type)
   ) u_group_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_item (grp_item),
      .full      (grp_full),
      .pop       (grp_pop),
      .head      (grp_head),
      .empty     (grp_empty),
      .level     (grp_level)
   );

   pyrc_back #(
      .PIXEL_DEPTH (PIXEL_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .grp_empty (grp_empty),
      .grp_head  (grp_head),
      .grp_pop   (grp_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_pixel (rsp_pixel)
   );

   assign rsp_red       = rsp_pixel.red;
   assign rsp_green     = rsp_pixel.green;
   assign rsp_blue      = rsp_pixel.blue;
   assign rsp_group_end = rsp_pixel.group_end;

`ifndef NO_ASSERTIONS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      grp_level <= ($clog2(GROUP_DEPTH+1))'(GROUP_DEPTH))
      else $error("group queue level out of range");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      grp_push |-> !grp_full)
      else $error("group word issued into a full queue");
   a_pop_has_word: assert property (@(posedge clock) disable iff (reset)
      grp_pop |-> !grp_empty)
      else $error("group word taken from an empty queue");
`endif

endmodule
